// ===== hdl/fups_pkg.sv =====
package fups_pkg;

    localparam int GROUPS_PER_LINE = 40;
    localparam int OUT_LINES       = 320;

    localparam int PIX_W     = 8;
    localparam int SRC_W     = 32;
    localparam int HALF_W    = 48;
    localparam int GROUP_W   = 6;
    localparam int ROW_W     = 9;
    localparam int PHASE_W   = 3;
    localparam int LINE_W    = $clog2(OUT_LINES);

    localparam int S_TDATA_W = 2 * SRC_W;
    localparam int M_FIELD_W = 2 * HALF_W + ROW_W + GROUP_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;
    localparam int OFS_ROW   = 2 * HALF_W;
    localparam int OFS_GROUP = OFS_ROW + ROW_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(4);
    localparam logic [GROUP_W-1:0] GROUP_LAST = GROUP_W'(GROUPS_PER_LINE - 1);

    typedef struct packed {
        logic [HALF_W-1:0]  pix_lo;
        logic [HALF_W-1:0]  pix_hi;
        logic [ROW_W-1:0]   row;
        logic [GROUP_W-1:0] group;
        logic               rep_en;
        logic [ROW_W-1:0]   rep_row;
    } fups_cmd_t;

    typedef enum logic {
        BK_PASS,
        BK_REPLAY
    } fups_bk_state_t;

    typedef struct packed {
        logic replaying;
        logic rp_valid;
    } fups_bk_stat_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } fups_q_stat_t;

    function automatic logic [HALF_W-1:0] expand4(input logic [SRC_W-1:0] src);
        logic [PIX_W-1:0] p0, p1, p2, p3;
        p0 = src[7:0];
        p1 = src[15:8];
        p2 = src[23:16];
        p3 = src[31:24];
        return {p3, p2, p2, p1, p0, p0};
    endfunction

    function automatic logic [ROW_W-1:0] line_to_row(input logic [LINE_W-1:0] l);
        logic [LINE_W+ROW_W-1:0] e;
        e = {{ROW_W{1'b0}}, l};
        return e[ROW_W-1:0];
    endfunction

endpackage

// ===== hdl/fups_front.sv =====
module fups_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_frame_start,
    input  logic [fups_pkg::SRC_W-1:0]   s_lo,
    input  logic [fups_pkg::SRC_W-1:0]   s_hi,
    output logic                         s_ready,
    output logic                         q_push,
    output fups_pkg::fups_cmd_t          q_cmd,
    input  logic                         q_ready
);
    import fups_pkg::*;

    logic [GROUP_W-1:0] group_count_reg, group_count_next;
    logic [PHASE_W-1:0] row_phase_reg, row_phase_next;
    logic [LINE_W-1:0]  out_line_reg, out_line_next;

    logic [GROUP_W-1:0] grp, g;
    logic [PHASE_W-1:0] phase;
    logic [LINE_W-1:0]  line;
    logic [LINE_W:0]    sum1, sum2;
    logic [LINE_W-1:0]  line_p1, line_p2;
    logic               row_end, rep_en, accept;

    always_comb begin
        grp   = s_frame_start ? '0 : group_count_reg;
        phase = s_frame_start ? '0 : row_phase_reg;
        line  = s_frame_start ? '0 : out_line_reg;
        g     = (grp > GROUP_LAST) ? GROUP_LAST : grp;

        row_end = (g == GROUP_LAST);
        rep_en  = row_end && (phase inside {PHASE_W'(0), PHASE_W'(1), PHASE_W'(3)});

        sum1 = {1'b0, line} + (LINE_W + 1)'(1);
        sum2 = {1'b0, line} + (LINE_W + 1)'(2);
        if (sum1 >= (LINE_W + 1)'(OUT_LINES)) begin
            sum1 = sum1 - (LINE_W + 1)'(OUT_LINES);
        end
        if (sum2 >= (LINE_W + 1)'(OUT_LINES)) begin
            sum2 = sum2 - (LINE_W + 1)'(OUT_LINES);
        end
        line_p1 = sum1[LINE_W-1:0];
        line_p2 = sum2[LINE_W-1:0];
    end

    assign accept  = s_valid && q_ready;
    assign s_ready = q_ready;
    assign q_push  = accept;

    always_comb begin
        q_cmd.pix_lo  = expand4(s_lo);
        q_cmd.pix_hi  = expand4(s_hi);
        q_cmd.row     = line_to_row(line);
        q_cmd.group   = g;
        q_cmd.rep_en  = rep_en;
        q_cmd.rep_row = line_to_row(line_p1);
    end

    always_comb begin
        group_count_next = group_count_reg;
        row_phase_next   = row_phase_reg;
        out_line_next    = out_line_reg;
        if (accept) begin
            if (row_end) begin
                group_count_next = '0;
                row_phase_next   = (phase >= PHASE_LAST) ? '0 : phase + PHASE_W'(1);
                out_line_next    = rep_en ? line_p2 : line_p1;
            end else begin
                group_count_next = g + GROUP_W'(1);
                row_phase_next   = phase;
                out_line_next    = line;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_count_reg <= '0;
            row_phase_reg   <= '0;
            out_line_reg    <= '0;
        end else begin
            group_count_reg <= group_count_next;
            row_phase_reg   <= row_phase_next;
            out_line_reg    <= out_line_next;
        end
    end

endmodule

// ===== hdl/fups_queue.sv =====
module fups_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fups_pkg::fups_cmd_t   push_cmd,
    output logic                  push_ready,
    input  logic                  pop,
    output logic                  head_valid,
    output fups_pkg::fups_cmd_t   head_cmd,
    output fups_pkg::fups_q_stat_t q_stat
);
    import fups_pkg::*;

    fups_cmd_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready   = (count_reg != QCNT_W'(QDEPTH));
    assign head_valid   = (count_reg != '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign q_stat.count = count_reg;

    assign do_push = push && push_ready;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/fups_back.sv =====
module fups_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  fups_pkg::fups_cmd_t            q_cmd,
    output logic                           q_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fups_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    output fups_pkg::fups_bk_stat_t        bk_stat
);
    import fups_pkg::*;

    logic [2*HALF_W-1:0] line_mem [GROUPS_PER_LINE];

    fups_bk_state_t      state_reg, state_next;
    logic [GROUP_W-1:0]  rep_idx_reg, rep_idx_next;
    logic [ROW_W-1:0]    rep_row_reg;
    logic [2*HALF_W-1:0] rd_data_reg;
    logic [GROUP_W-1:0]  rp_group_reg;
    logic                rp_valid_reg, rp_valid_next;

    logic                m_valid_reg, m_valid_next;
    logic [HALF_W-1:0]   m_lo_reg, m_hi_reg;
    logic [ROW_W-1:0]    m_row_reg;
    logic [GROUP_W-1:0]  m_group_reg;
    logic                m_last_reg;

    logic out_free, pop, issue, rp_take, issue_last;

    assign out_free = !m_valid_reg || m_axis_tready;
    assign rp_take  = rp_valid_reg && out_free;

    always_comb begin
        pop        = 1'b0;
        issue      = 1'b0;
        issue_last = 1'b0;
        case (state_reg)
            BK_PASS: begin
                pop = q_valid && !rp_valid_reg && out_free;
            end
            BK_REPLAY: begin
                issue      = !rp_valid_reg || out_free;
                issue_last = issue && (rep_idx_reg == GROUP_LAST);
            end
            default: begin
                pop   = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_PASS: begin
                if (pop && q_cmd.rep_en) begin
                    state_next = BK_REPLAY;
                end
            end
            BK_REPLAY: begin
                if (issue_last) begin
                    state_next = BK_PASS;
                end
            end
            default: begin
                state_next = BK_PASS;
            end
        endcase
    end

    always_comb begin
        rep_idx_next = rep_idx_reg;
        if (pop) begin
            rep_idx_next = '0;
        end else if (issue) begin
            rep_idx_next = rep_idx_reg + GROUP_W'(1);
        end
        rp_valid_next = issue ? 1'b1 : (rp_take ? 1'b0 : rp_valid_reg);
        m_valid_next  = (pop || rp_take) ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
    end

    assign q_pop             = pop;
    assign bk_stat.replaying = (state_reg == BK_REPLAY);
    assign bk_stat.rp_valid  = rp_valid_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            line_mem[q_cmd.group] <= {q_cmd.pix_hi, q_cmd.pix_lo};
        end
        if (issue) begin
            rd_data_reg <= line_mem[rep_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            rep_row_reg <= q_cmd.rep_row;
        end
        if (issue) begin
            rp_group_reg <= rep_idx_reg;
        end
        if (pop) begin
            m_lo_reg    <= q_cmd.pix_lo;
            m_hi_reg    <= q_cmd.pix_hi;
            m_row_reg   <= q_cmd.row;
            m_group_reg <= q_cmd.group;
            m_last_reg  <= !q_cmd.rep_en;
        end else if (rp_take) begin
            m_lo_reg    <= rd_data_reg[HALF_W-1:0];
            m_hi_reg    <= rd_data_reg[2*HALF_W-1:HALF_W];
            m_row_reg   <= rep_row_reg;
            m_group_reg <= rp_group_reg;
            m_last_reg  <= (rp_group_reg == GROUP_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_PASS;
            rep_idx_reg  <= '0;
            rp_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rep_idx_reg  <= rep_idx_next;
            rp_valid_reg <= rp_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_group_reg, m_row_reg, m_hi_reg, m_lo_reg};

endmodule

// ===== hdl/frame_upscale_3to2_8to5_core.sv =====
// An input beat passes the command queue, then the output register, before its first output beat is valid.
// Throughput: one input and one output beat per cycle while no line is replayed and m_axis_tready is high.
// A row end that repeats its line yields 41 output beats: its own and a replay of all 40 stored groups,
// read one entry per cycle from the single-port line store while the output is not stalled.
// Reset clears the row, line and group counters, the command queue and the output valid.
// The line store is not cleared; every entry is written before a replay reads it.
module frame_upscale_3to2_8to5_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // src_pixels_low, src_pixels_high
    input  logic [fups_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // frame_start
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_pixels_low, out_pixels_high, out_row, out_group, zero padding
    output logic [fups_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import fups_pkg::*;

    logic          q_push, q_ready, q_valid, q_pop;
    fups_cmd_t     push_cmd, head_cmd;
    fups_q_stat_t  q_stat;
    fups_bk_stat_t bk_stat;

    fups_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_axis_tvalid),
        .s_frame_start (s_axis_tuser),
        .s_lo          (s_axis_tdata[SRC_W-1:0]),
        .s_hi          (s_axis_tdata[2*SRC_W-1:SRC_W]),
        .s_ready       (s_axis_tready),
        .q_push        (q_push),
        .q_cmd         (push_cmd),
        .q_ready       (q_ready)
    );

    fups_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd),
        .q_stat     (q_stat)
    );

    fups_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .bk_stat       (bk_stat)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("command queue holds more entries than its depth");

    a_group_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[OFS_GROUP+GROUP_W-1:OFS_GROUP] <= GROUP_LAST)
        else $error("output group index out of range");

    a_replay_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tlast
         && m_axis_tdata[OFS_GROUP+GROUP_W-1:OFS_GROUP] == GROUP_LAST)
        |-> (bk_stat.replaying || bk_stat.rp_valid))
        else $error("repeated row end without a line replay in progress");

    a_no_pop_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.replaying |-> !q_pop)
        else $error("command taken from the queue during a line replay");

endmodule
